FILE: src/taep_pkg.sv
`default_nettype none
package taep_pkg;
   localparam int FRAC_BITS = 16;
   localparam int MIN_AXIS_LSB = 7;
   localparam int SQ_W = 66;
   localparam int LEN_W = 34;
   localparam int DIV_W = LEN_W + FRAC_BITS;
   localparam int AXIS_W = FRAC_BITS + 2;
   localparam int PROJ_W = 32 + AXIS_W + 2;

   // The last member sits in the lowest bits, so vertex A x lands at bit 0.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] z2, y2, x2, z1, y1, x1, z0, y0, x0;
   } tri_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction
endpackage
`default_nettype wire

FILE: src/triangle_axis_extension_pad.sv
// Channel | Ports        | Content
// req     | req_t*       | one triangle item (tuser = is_threshold)
// rsp     | rsp_t*       | one result item (tuser = pad_valid)
// csr     | csr_we/wdata | extension register
// One item may enter every cycle while rsp is not stalled; its result passes
// through 89 register stages: input setup, 34 square-root digit stages,
// select, 50 divider digit stages, axis, side and output.
// The long chains (square root and division) run one digit per stage.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits, the extension and the pad counter.
`default_nettype none
module triangle_axis_extension_pad
   import taep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ax, ay, az, bx, by_coord, bz, cx, cy, cz, object_id (LSB first)
   input  wire logic [303:0] req_tdata,
   // is_threshold
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pax, pay, paz, pbx, pby, pbz, pcx, pcy, pcz, pad_object_id, pads_made
   output logic [335:0]      rsp_tdata,
   // pad_valid
   output logic              rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [30:0]  csr_wdata
);
   localparam int NS = LEN_W;      // sqrt stages
   localparam int ND = DIV_W;      // divider stages

   logic [30:0] ext_ff;
   logic [31:0] cnt_ff, cnt_in;
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) ext_ff <= '0;
      else if (csr_we) ext_ff <= csr_wdata;
   end

   // Stage 0: register input, squared edge lengths.
   logic v0_ff, go0_ff;
   tri_type t0_ff;
   logic [SQ_W-1:0] n0_ff [3];
   logic signed [32:0] d0x_ff [3], d0z_ff [3];
   tri_type tin;
   assign tin = req_tdata;
   logic signed [31:0] px [3], pz [3];
   assign px[0] = tin.x0; assign px[1] = tin.x1; assign px[2] = tin.x2;
   assign pz[0] = tin.z0; assign pz[1] = tin.z1; assign pz[2] = tin.z2;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
      if (adv) begin
         t0_ff <= tin;
         go0_ff <= req_tuser && ext_ff != '0;
         for (int e = 0; e < 3; e++) begin
            logic signed [32:0] dx, dz;
            logic [32:0] mx, mz;
            dx = 33'(px[(e+1)%3]) - 33'(px[e]);
            dz = 33'(pz[(e+1)%3]) - 33'(pz[e]);
            mx = mag33(dx); mz = mag33(dz);
            d0x_ff[e] <= dx; d0z_ff[e] <= dz;
            n0_ff[e] <= SQ_W'(mx * mx) + SQ_W'(mz * mz);
         end
      end
   end

   // Square-root pipeline: one root bit per stage per edge; the remainder
   // travels with the partial root.
   logic vs_ff [NS+1];
   logic gos_ff [NS+1];
   tri_type ts_ff [NS+1];
   logic [SQ_W-1:0] ns_ff [NS+1][3];
   logic [LEN_W-1:0] rs_ff [NS+1][3];
   logic signed [32:0] dxs_ff [NS+1][3], dzs_ff [NS+1][3];
   always_comb begin
      vs_ff[0] = v0_ff; gos_ff[0] = go0_ff; ts_ff[0] = t0_ff;
      for (int e = 0; e < 3; e++) begin
         ns_ff[0][e] = n0_ff[e]; rs_ff[0][e] = '0;
         dxs_ff[0][e] = d0x_ff[e]; dzs_ff[0][e] = d0z_ff[e];
      end
   end
   for (genvar s = 0; s < NS; s++) begin : g_sq
      logic [LEN_W-1:0] rn [3];
      logic [SQ_W-1:0] rem_nx [3];
      for (genvar e = 0; e < 3; e++) begin : g_e
         taep_sqrt_stage u_st (
            .rem_in(ns_ff[s][e]), .root_in(rs_ff[s][e]),
            .bit_idx(6'(NS-1-s)), .rem_out(rem_nx[e]), .root_out(rn[e]));
      end
      logic v_ff, g_ff;
      tri_type t_ff;
      logic [SQ_W-1:0] n_ff [3];
      logic [LEN_W-1:0] r_ff [3];
      logic signed [32:0] x_ff [3], z_ff [3];
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= vs_ff[s];
         if (adv) begin
            g_ff <= gos_ff[s]; t_ff <= ts_ff[s];
            for (int e = 0; e < 3; e++) begin
               n_ff[e] <= rem_nx[e]; r_ff[e] <= rn[e];
               x_ff[e] <= dxs_ff[s][e]; z_ff[e] <= dzs_ff[s][e];
            end
         end
      end
      always_comb begin
         vs_ff[s+1] = v_ff; gos_ff[s+1] = g_ff; ts_ff[s+1] = t_ff;
         for (int e = 0; e < 3; e++) begin
            ns_ff[s+1][e] = n_ff[e]; rs_ff[s+1][e] = r_ff[e];
            dxs_ff[s+1][e] = x_ff[e]; dzs_ff[s+1][e] = z_ff[e];
         end
      end
   end

   // Select stage: shortest edge, acceptance, axis numerators.
   logic v1_ff, ok1_ff, sx1_ff, sz1_ff;
   tri_type t1_ff;
   logic [LEN_W-1:0] sh1_ff;
   logic [DIV_W-1:0] nx1_ff, nz1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= vs_ff[NS];
      if (adv) begin
         logic [LEN_W-1:0] l0, l1, l2, sh, lg;
         logic [1:0] se;
         logic signed [32:0] dx, dz;
         l0 = rs_ff[NS][0]; l1 = rs_ff[NS][1]; l2 = rs_ff[NS][2];
         sh = l0; se = 2'd0; lg = l0;
         if (l1 < sh) begin sh = l1; se = 2'd1; end
         if (l2 < sh) begin sh = l2; se = 2'd2; end
         if (l1 > lg) lg = l1;
         if (l2 > lg) lg = l2;
         dx = dxs_ff[NS][se]; dz = dzs_ff[NS][se];
         t1_ff <= ts_ff[NS];
         ok1_ff <= gos_ff[NS] && sh >= LEN_W'(MIN_AXIS_LSB)
                   && (LEN_W+1)'(lg) > {sh, 1'b0};
         sh1_ff <= sh;
         sx1_ff <= dx[32]; sz1_ff <= dz[32];
         nx1_ff <= DIV_W'(mag33(dx)) << FRAC_BITS;
         nz1_ff <= DIV_W'(mag33(dz)) << FRAC_BITS;
      end
   end

   // Divider pipeline: restoring, one quotient bit per stage, two lanes.
   logic vd_ff [ND+1], okd_ff [ND+1], sxd_ff [ND+1], szd_ff [ND+1];
   tri_type td_ff [ND+1];
   logic [LEN_W-1:0] dv_ff [ND+1];
   logic [DIV_W-1:0] nxd_ff [ND+1], nzd_ff [ND+1];
   logic [LEN_W:0] rxd_ff [ND+1], rzd_ff [ND+1];
   always_comb begin
      vd_ff[0] = v1_ff; okd_ff[0] = ok1_ff; sxd_ff[0] = sx1_ff;
      szd_ff[0] = sz1_ff; td_ff[0] = t1_ff; dv_ff[0] = sh1_ff;
      nxd_ff[0] = nx1_ff; nzd_ff[0] = nz1_ff; rxd_ff[0] = '0; rzd_ff[0] = '0;
   end
   for (genvar s = 0; s < ND; s++) begin : g_dv
      logic v_ff, ok_ff, sx_ff, sz_ff;
      tri_type t_ff;
      logic [LEN_W-1:0] d_ff;
      logic [DIV_W-1:0] qx_ff, qz_ff;
      logic [LEN_W:0] rx_ff, rz_ff;
      logic [LEN_W+1:0] tx, tz;
      always_comb begin
         tx = {rxd_ff[s], nxd_ff[s][DIV_W-1]};
         tz = {rzd_ff[s], nzd_ff[s][DIV_W-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= vd_ff[s];
         if (adv) begin
            ok_ff <= okd_ff[s]; sx_ff <= sxd_ff[s]; sz_ff <= szd_ff[s];
            t_ff <= td_ff[s]; d_ff <= dv_ff[s];
            if (dv_ff[s] != '0 && tx >= (LEN_W+2)'(dv_ff[s])) begin
               rx_ff <= (LEN_W+1)'(tx - (LEN_W+2)'(dv_ff[s]));
               qx_ff <= {nxd_ff[s][DIV_W-2:0], 1'b1};
            end else begin
               rx_ff <= (LEN_W+1)'(tx);
               qx_ff <= {nxd_ff[s][DIV_W-2:0], 1'b0};
            end
            if (dv_ff[s] != '0 && tz >= (LEN_W+2)'(dv_ff[s])) begin
               rz_ff <= (LEN_W+1)'(tz - (LEN_W+2)'(dv_ff[s]));
               qz_ff <= {nzd_ff[s][DIV_W-2:0], 1'b1};
            end else begin
               rz_ff <= (LEN_W+1)'(tz);
               qz_ff <= {nzd_ff[s][DIV_W-2:0], 1'b0};
            end
         end
      end
      always_comb begin
         vd_ff[s+1] = v_ff; okd_ff[s+1] = ok_ff; sxd_ff[s+1] = sx_ff;
         szd_ff[s+1] = sz_ff; td_ff[s+1] = t_ff; dv_ff[s+1] = d_ff;
         nxd_ff[s+1] = qx_ff; nzd_ff[s+1] = qz_ff;
         rxd_ff[s+1] = rx_ff; rzd_ff[s+1] = rz_ff;
      end
   end

   // Axis stage: signed axis, push magnitudes, projections.
   logic v2_ff, ok2_ff;
   tri_type t2_ff;
   logic signed [AXIS_W-1:0] ax2_ff, az2_ff;
   logic [31:0] mx2_ff, mz2_ff;
   logic signed [PROJ_W-1:0] pr2_ff [3];
   logic signed [31:0] qx [3], qz [3];
   assign qx[0] = td_ff[ND].x0; assign qx[1] = td_ff[ND].x1;
   assign qx[2] = td_ff[ND].x2;
   assign qz[0] = td_ff[ND].z0; assign qz[1] = td_ff[ND].z1;
   assign qz[2] = td_ff[ND].z2;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= vd_ff[ND];
      if (adv) begin
         logic [AXIS_W-1:0] mgx, mgz;
         logic signed [AXIS_W-1:0] sx, sz;
         mgx = AXIS_W'(nxd_ff[ND]); mgz = AXIS_W'(nzd_ff[ND]);
         sx = sxd_ff[ND] ? AXIS_W'(-mgx) : mgx;
         sz = szd_ff[ND] ? AXIS_W'(-mgz) : mgz;
         ax2_ff <= sx; az2_ff <= sz;
         mx2_ff <= 32'((64'(mgx) * 64'(ext_ff)) >> FRAC_BITS);
         mz2_ff <= 32'((64'(mgz) * 64'(ext_ff)) >> FRAC_BITS);
         for (int i = 0; i < 3; i++)
            pr2_ff[i] <= PROJ_W'(qx[i] * sx) + PROJ_W'(qz[i] * sz);
         ok2_ff <= okd_ff[ND]; t2_ff <= td_ff[ND];
      end
   end

   // Side stage: min/max of projections and direction per vertex.
   logic v3_ff, ok3_ff, axn3_ff, azn3_ff;
   logic neg3_ff [3];
   tri_type t3_ff;
   logic [31:0] mx3_ff, mz3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         logic signed [PROJ_W-1:0] mn, mxp;
         mn = pr2_ff[0]; mxp = pr2_ff[0];
         for (int i = 1; i < 3; i++) begin
            if (pr2_ff[i] < mn) mn = pr2_ff[i];
            if (pr2_ff[i] > mxp) mxp = pr2_ff[i];
         end
         for (int i = 0; i < 3; i++)
            neg3_ff[i] <= ((PROJ_W+1)'(pr2_ff[i]) <<< 1)
                          < ((PROJ_W+1)'(mn) + (PROJ_W+1)'(mxp));
         ok3_ff <= ok2_ff; t3_ff <= t2_ff;
         axn3_ff <= ax2_ff < 0; azn3_ff <= az2_ff < 0;
         mx3_ff <= mx2_ff; mz3_ff <= mz2_ff;
      end
   end

   // Output stage: saturating push, counter.
   function automatic logic [31:0] push(input logic [31:0] c, input logic [31:0] m,
                                        input logic flip);
      logic signed [33:0] r;
      r = flip ? 34'(signed'(c)) - 34'(m) : 34'(signed'(c)) + 34'(m);
      if (r > 34'sh07FFFFFFF) push = 32'h7FFFFFFF;
      else if (r < -34'sh080000000) push = 32'h80000000;
      else push = 32'(r);
   endfunction

   logic pv;
   logic [303:0] body;
   assign pv = ok3_ff;
   always_comb begin
      cnt_in = cnt_ff;
      if (v3_ff && adv && pv && cnt_ff != '1) cnt_in = cnt_ff + 32'd1;
      body = '0;
      if (pv) begin
         body[31:0]    = push(t3_ff.x0, mx3_ff, axn3_ff != neg3_ff[0]);
         body[63:32]   = t3_ff.y0;
         body[95:64]   = push(t3_ff.z0, mz3_ff, azn3_ff != neg3_ff[0]);
         body[127:96]  = push(t3_ff.x1, mx3_ff, axn3_ff != neg3_ff[1]);
         body[159:128] = t3_ff.y1;
         body[191:160] = push(t3_ff.z1, mz3_ff, azn3_ff != neg3_ff[1]);
         body[223:192] = push(t3_ff.x2, mx3_ff, axn3_ff != neg3_ff[2]);
         body[255:224] = t3_ff.y2;
         body[287:256] = push(t3_ff.z2, mz3_ff, azn3_ff != neg3_ff[2]);
         body[303:288] = t3_ff.id;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
         cnt_ff <= '0;
      end else if (adv) begin
         rsp_tvalid <= v3_ff;
         cnt_ff <= cnt_in;
      end
      if (adv) begin
         rsp_tuser <= pv;
         rsp_tdata <= {cnt_in, body};
      end
   end

`ifndef SYNTHESIS
   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      cnt_ff >= $past(cnt_ff)) else $error("counter went back");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed under stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[303:0] == '0)
      else $error("rejected item not cleared");
`endif
endmodule
`default_nettype wire

FILE: src/taep_sqrt_stage.sv
`default_nettype none
module taep_sqrt_stage
   import taep_pkg::*;
(
   input  wire logic [SQ_W-1:0]  rem_in,
   input  wire logic [LEN_W-1:0] root_in,
   input  wire logic [5:0]       bit_idx,
   output logic [SQ_W-1:0]       rem_out,
   output logic [LEN_W-1:0]      root_out
);
   // One restoring digit on the remainder: setting root bit k adds
   // root*2^(k+1) + 2^(2k) to the square, so take it if the remainder covers it.
   logic [2*LEN_W-1:0] step;
   always_comb begin
      step = ((2*LEN_W)'(root_in) << (bit_idx + 1))
             | ((2*LEN_W)'(1) << {bit_idx, 1'b0});
      if (step <= (2*LEN_W)'(rem_in)) begin
         rem_out = SQ_W'((2*LEN_W)'(rem_in) - step);
         root_out = root_in | (LEN_W'(1) << bit_idx);
      end else begin
         rem_out = rem_in;
         root_out = root_in;
      end
   end
endmodule
`default_nettype wire

FILE: bench/triangle_axis_extension_pad_test.sv
`default_nettype none
module triangle_axis_extension_pad_test
   import taep_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One triangle as it travels on the request channel.
   typedef struct {
      bit          thr;
      logic [31:0] c[9];   // ax, ay, az, bx, by, bz, cx, cy, cz
      logic [15:0] id;
   } tri_item;

   // One pad result as it travels on the response channel.
   typedef struct {
      bit          valid;
      logic [31:0] p[9];
      logic [15:0] id;
      logic [31:0] cnt;
   } pad_result;

   // A row of the directed table. Only X and Z matter for the geometry, so
   // Y is filled in with extreme values by the loop. Rows marked obvious carry
   // an expectation that is plain from the rules: no pad, zero fields.
   typedef struct {
      logic [30:0] ext;
      bit          thr;
      int          ax, az, bx, bz, cx, cz;
      bit          obvious;
   } table_row;

   localparam int ROWS = 15;
   localparam int RANDOM_ITEMS = 950;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 120;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [303:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [335:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 0;
   logic [30:0]  csr_wdata = '0;

   triangle_axis_extension_pad dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the block's register and pad counter.
   logic [30:0] extension_shadow = '0;
   logic [31:0] pads_shadow = '0;

   pad_result pending_pads[$];
   int errors = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int rsp_cycle = 0;
   table_row rows[ROWS];

   // Truncated square root of a 66-bit sum of squares, one bit at a time.
   function automatic longint edge_length(longint dx, longint dz);
      logic [32:0] mx, mz;
      logic [65:0] sum;
      logic [67:0] trial, root;
      mx = dx < 0 ? 33'(-dx) : 33'(dx);
      mz = dz < 0 ? 33'(-dz) : 33'(dz);
      sum = 66'(mx) * 66'(mx) + 66'(mz) * 66'(mz);
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         trial = root | (68'd1 << i);
         if (trial * trial <= 68'(sum))
            root = trial;
      end
      return longint'(root);
   endfunction

   // Unit-axis component in Q.FRAC_BITS: magnitude truncated, sign restored.
   function automatic longint axis_part(longint d, longint len);
      longint q;
      q = ((d < 0 ? -d : d) <<< FRAC_BITS) / len;
      return d < 0 ? -q : q;
   endfunction

   // Push one coordinate along the axis and clamp to the signed 32-bit range.
   function automatic logic [31:0] pushed(longint c, longint axis, bit neg);
      longint off, r;
      off = ((axis < 0 ? -axis : axis) * longint'(extension_shadow)) >>> FRAC_BITS;
      if ((axis < 0) != neg)
         off = -off;
      r = c + off;
      if (r > 64'sd2147483647)
         r = 64'sd2147483647;
      if (r < -64'sd2147483648)
         r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // Works out the pad for one accepted triangle and advances the counter.
   function automatic pad_result predict_pad(tri_item t);
      pad_result r;
      longint x[3], y[3], z[3], len[3], pr[3];
      longint shortest, longest, axx, azz, pmin, pmax;
      int se, nx;
      bit neg;
      r.valid = 0;
      r.id = '0;
      foreach (r.p[i]) r.p[i] = '0;
      for (int i = 0; i < 3; i++) begin
         x[i] = longint'($signed(t.c[3 * i]));
         y[i] = longint'($signed(t.c[3 * i + 1]));
         z[i] = longint'($signed(t.c[3 * i + 2]));
      end
      if (t.thr && extension_shadow != 0) begin
         for (int e = 0; e < 3; e++) begin
            nx = (e + 1) % 3;
            len[e] = edge_length(x[nx] - x[e], z[nx] - z[e]);
         end
         se = 0;
         shortest = len[0];
         longest = len[0];
         for (int e = 1; e < 3; e++) begin
            // Strict compare keeps the lowest edge number on a tie.
            if (len[e] < shortest) begin
               shortest = len[e];
               se = e;
            end
            if (len[e] > longest)
               longest = len[e];
         end
         if (shortest >= MIN_AXIS_LSB && longest > 2 * shortest) begin
            nx = (se + 1) % 3;
            axx = axis_part(x[nx] - x[se], shortest);
            azz = axis_part(z[nx] - z[se], shortest);
            for (int i = 0; i < 3; i++)
               pr[i] = x[i] * axx + z[i] * azz;
            pmin = pr[0];
            pmax = pr[0];
            for (int i = 1; i < 3; i++) begin
               if (pr[i] < pmin) pmin = pr[i];
               if (pr[i] > pmax) pmax = pr[i];
            end
            for (int i = 0; i < 3; i++) begin
               neg = 2 * pr[i] < pmin + pmax;
               r.p[3 * i] = pushed(x[i], axx, neg);
               r.p[3 * i + 1] = y[i][31:0];
               r.p[3 * i + 2] = pushed(z[i], azz, neg);
            end
            r.valid = 1;
            r.id = t.id;
            if (pads_shadow != 32'hFFFF_FFFF)
               pads_shadow++;
         end
      end
      r.cnt = pads_shadow;
      return r;
   endfunction

   // Drives one triangle at the falling edge and waits for its handshake.
   // The sender runs in bursts; between bursts valid may drop for a random gap.
   task automatic send_triangle(tri_item t, bit obvious);
      pad_result r;
      if (burst_left == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      for (int i = 0; i < 9; i++)
         req_tdata[32 * i +: 32] = t.c[i];
      req_tdata[303:288] = t.id;
      req_tuser = t.thr;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      if (obvious) begin
         // No pad: every field is zero and the count stays where it was.
         r.valid = 0;
         r.id = '0;
         foreach (r.p[i]) r.p[i] = '0;
         r.cnt = pads_shadow;
      end else begin
         r = predict_pad(t);
      end
      pending_pads.insert(pending_pads.size(), r);
      @(negedge clock);
   endtask

   // Lets every expected pad arrive, then a few more cycles for good measure.
   task automatic drain_pads();
      req_tvalid = 0;
      burst_left = 0;
      while (pending_pads.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // The register is written only while the pipeline is empty.
   task automatic write_extension(logic [30:0] value);
      drain_pads();
      csr_wdata = value;
      csr_we = 1;
      @(negedge clock);
      csr_we = 0;
      extension_shadow = value;
   endtask

   function automatic logic [31:0] rand_coord(int shift);
      return 32'($signed($urandom) >>> shift);
   endfunction

   // A sliver: two vertices close together and one far away, in random order.
   // Small scales hit the degenerate threshold; large ones wrap and saturate.
   function automatic tri_item make_sliver(bit thr);
      tri_item t;
      int s, rot;
      longint bx0, bz0, dx, dz, fx, fz;
      longint vx[3], vz[3];
      s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 20);
      dx = longint'($signed($urandom) >>> (31 - s));
      dz = longint'($signed($urandom) >>> (31 - s));
      fx = longint'($signed($urandom) >>> (31 - s - $urandom_range(2, 8)));
      fz = longint'($signed($urandom) >>> (31 - s - $urandom_range(2, 8)));
      bx0 = longint'($signed(rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(4, 16))));
      bz0 = longint'($signed(rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(4, 16))));
      vx[0] = bx0;      vz[0] = bz0;
      vx[1] = bx0 + dx; vz[1] = bz0 + dz;
      vx[2] = bx0 + fx; vz[2] = bz0 + fz;
      rot = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         t.c[3 * i] = 32'(vx[(i + rot) % 3]);
         t.c[3 * i + 1] = $urandom;
         t.c[3 * i + 2] = 32'(vz[(i + rot) % 3]);
      end
      t.thr = thr;
      t.id = 16'($urandom);
      return t;
   endfunction

   // Response side: stalls follow a pattern that steps through four modes,
   // from always ready to sparse, so stalls land on every pipeline phase.
   always @(negedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      case ((rsp_cycle / 256) % 4)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 3) != 0;
         2: rsp_tready <= (rsp_cycle % 7) < 4;
         default: rsp_tready <= $urandom_range(0, 2) == 0;
      endcase
   end

   // Checks every accepted pad against the oldest expectation.
   always @(posedge clock) begin
      pad_result e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pads.size() == 0) begin
            $error("pad item arrived with nothing expected");
            errors++;
         end else begin
            e = pending_pads.pop_front();
            if (rsp_tuser !== e.valid) begin
               $error("pad_valid: expected %0d, got %0d", e.valid, rsp_tuser);
               errors++;
            end
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[32 * i +: 32] !== e.p[i]) begin
                  $error("%s: expected %h, got %h",
                         i == 0 ? "pax" : i == 1 ? "pay" : i == 2 ? "paz" :
                         i == 3 ? "pbx" : i == 4 ? "pby" : i == 5 ? "pbz" :
                         i == 6 ? "pcx" : i == 7 ? "pcy" : "pcz",
                         e.p[i], rsp_tdata[32 * i +: 32]);
                  errors++;
               end
            if (rsp_tdata[303:288] !== e.id) begin
               $error("pad_object_id: expected %h, got %h", e.id, rsp_tdata[303:288]);
               errors++;
            end
            if (rsp_tdata[335:304] !== e.cnt) begin
               $error("pads_made: expected %0d, got %0d", e.cnt, rsp_tdata[335:304]);
               errors++;
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake on either side is a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      tri_item t;
      int phase_ext;
      // Directed table. The sliver A(0,0) B(16,0) C(8,4000) puts C exactly on
      // the midpoint of the projection range, which must push it forward.
      rows[0]  = '{31'd0, 1, 0, 0, 16, 0, 8, 4000, 1};
      rows[1]  = '{31'h10000, 0, 0, 0, 16, 0, 8, 4000, 1};
      rows[2]  = '{31'h10000, 1, 0, 0, 16, 0, 8, 4000, 0};
      // All three vertices on one point: three tied edges of length zero.
      rows[3]  = '{31'h10000, 1, 5, 5, 5, 5, 5, 5, 1};
      // Shortest edge just below and just at the degenerate limit.
      rows[4]  = '{31'h10000, 1, 0, 0, 6, 0, 3, 3000, 1};
      rows[5]  = '{31'h10000, 1, 0, 0, 7, 0, 3, 3000, 0};
      // Near equilateral, and longest edge exactly twice the shortest.
      rows[6]  = '{31'h10000, 1, 0, 0, 100, 0, 50, 87, 1};
      rows[7]  = '{31'h10000, 1, 0, 0, 10, 0, 20, 0, 1};
      // Shortest edge as B to C, then as C to A, then as A to B.
      rows[8]  = '{31'h10000, 1, 0, 5000, -300, -20, -290, -25, 0};
      rows[9]  = '{31'h10000, 1, 100, 100, 90000, -7000, 105, 90, 0};
      rows[10] = '{31'h10000, 1, -70000, -70000, -70050, -69970, -400000, 250000, 0};
      // Full extension at the corners of the range saturates; then extension 1.
      rows[11] = '{31'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FF37, 32'h7FFF_FFFF, 0, 0, 0};
      rows[12] = '{31'h7FFF_FFFF, 1, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_012C, 32'h8000_000A, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0};
      rows[13] = '{31'd1, 1, 0, 0, 16, 0, 8, 4000, 0};
      rows[14] = '{31'd1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 0, -1, 1};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (rows[k]) begin
         if (rows[k].ext != extension_shadow)
            write_extension(rows[k].ext);
         t.thr = rows[k].thr;
         t.c[0] = rows[k].ax; t.c[2] = rows[k].az;
         t.c[3] = rows[k].bx; t.c[5] = rows[k].bz;
         t.c[6] = rows[k].cx; t.c[8] = rows[k].cz;
         t.c[1] = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         t.c[4] = k[0] ? 32'h7FFF_FFFF : 32'h0000_0000;
         t.c[7] = k[0] ? 32'hFFFF_FFFF : 32'h8000_0000;
         t.id = k[0] ? 16'hFFFF : 16'(k);
         send_triangle(t, rows[k].obvious);
      end

      // Random part in five phases, each under its own extension setting.
      // Most items are slivers so that the push path sees heavy use.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: phase_ext = 32'h0001_0000;
            1: phase_ext = 32'h7FFF_FFFF;
            2: phase_ext = 0;
            3: phase_ext = $urandom_range(1, 32'h0040_0000);
            default: phase_ext = $urandom & 32'h7FFF_FFFF;
         endcase
         write_extension(31'(phase_ext));
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  t.thr = $urandom_range(0, 1);
                  foreach (t.c[i]) t.c[i] = $urandom;
                  t.id = 16'($urandom);
               end
               3, 4: t = make_sliver(0);
               default: t = make_sliver(1);
            endcase
            send_triangle(t, 0);
            // Once per phase the sender holds off until the pipeline empties.
            if (n == RANDOM_ITEMS / 10)
               drain_pads();
         end
      end

      req_tvalid = 0;
      while (pending_pads.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
src/taep_pkg.sv
src/taep_sqrt_stage.sv
src/triangle_axis_extension_pad.sv
bench/triangle_axis_extension_pad_test.sv
